### src/gapf_pkg.sv
// Shared types, codes and helpers for the graph A* path finder.
// No dependencies; every other file in src except gapf_ram refers to this package by scoped names.
package gapf_pkg;

  localparam int CRD_W  = 16;          // coordinate width, Q12.4 signed
  localparam int IDX_W  = 5;           // node index field width
  localparam int LIM_W  = 18;          // auto connect limit width
  localparam int D2_W   = 34;          // squared distance width
  localparam int RT_W   = 17;          // floor square root width
  localparam int COST_W = 24;          // path cost width

  localparam logic [COST_W-1:0] COST_INF = 24'hFFFFFF;
  localparam logic [COST_W-1:0] COST_MAX = 24'hFFFFFE;

  localparam logic [1:0] ACT_ADD     = 2'd0;
  localparam logic [1:0] ACT_CONNECT = 2'd1;
  localparam logic [1:0] ACT_AUTO    = 2'd2;
  localparam logic [1:0] ACT_FIND    = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_BAD_IDX = 3'd2;
  localparam logic [2:0] ST_NO_PATH = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_MESH  = 2'd1;
  localparam logic [1:0] KIND_GOAL  = 2'd2;

  typedef struct packed {
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic [1:0]              action;
    logic signed [CRD_W-1:0] pos_x;
    logic signed [CRD_W-1:0] pos_y;
    logic signed [CRD_W-1:0] pos_z;
    logic signed [CRD_W-1:0] goal_x;
    logic signed [CRD_W-1:0] goal_y;
    logic signed [CRD_W-1:0] goal_z;
    logic [IDX_W-1:0]        node_a;
    logic [IDX_W-1:0]        node_b;
    logic [LIM_W-1:0]        max_distance;
  } req_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [IDX_W-1:0]        node_index;
    logic [1:0]              point_kind;
    logic signed [CRD_W-1:0] out_x;
    logic signed [CRD_W-1:0] out_y;
    logic signed [CRD_W-1:0] out_z;
    logic                    last;
  } rsp_t;

  // Cost plus edge length, saturated one below infinity.
  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [RT_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + (COST_W+1)'(b);
    return (s > {1'b0, COST_MAX}) ? COST_MAX : s[COST_W-1:0];
  endfunction

endpackage

### src/gapf_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module gapf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/gapf_dist.sv
// Shared distance unit: squared Euclidean distance of two points, one axis per
// cycle on one multiplier, then a floor square root one result bit per cycle.
// Depends on gapf_pkg.
module gapf_dist (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  gapf_pkg::point_t             a,
  input  gapf_pkg::point_t             b,
  output logic                         done,
  output logic [gapf_pkg::D2_W-1:0]    dist2,
  output logic [gapf_pkg::RT_W-1:0]    root
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SUM  = 2'd1;
  localparam logic [1:0] PH_ROOT = 2'd2;

  logic [1:0]                      phase;
  logic [4:0]                      cnt;
  gapf_pkg::point_t                pa;
  gapf_pkg::point_t                pb;
  logic [gapf_pkg::D2_W-1:0]       xs;
  logic [gapf_pkg::RT_W:0]         rem;

  logic signed [gapf_pkg::CRD_W-1:0] ca;
  logic signed [gapf_pkg::CRD_W-1:0] cb;
  logic signed [gapf_pkg::CRD_W:0]   dif;
  logic [gapf_pkg::CRD_W-1:0]        mag;
  logic [2*gapf_pkg::CRD_W-1:0]      sq;
  logic [gapf_pkg::D2_W-1:0]         sum;
  logic [gapf_pkg::RT_W+2:0]         rsh;
  logic [gapf_pkg::RT_W+2:0]         trial;

  always_comb begin
    unique case (cnt[1:0])
      2'd0: begin ca = pa.x; cb = pb.x; end
      2'd1: begin ca = pa.y; cb = pb.y; end
      default: begin ca = pa.z; cb = pb.z; end
    endcase
    dif   = {ca[gapf_pkg::CRD_W-1], ca} - {cb[gapf_pkg::CRD_W-1], cb};
    mag   = dif[gapf_pkg::CRD_W] ? gapf_pkg::CRD_W'(-dif) : dif[gapf_pkg::CRD_W-1:0];
    sq    = mag * mag;
    sum   = dist2 + gapf_pkg::D2_W'(sq);
    rsh   = {rem, xs[gapf_pkg::D2_W-1 -: 2]};
    trial = {1'b0, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          done <= 1'b0;
          if (start) begin
            pa    <= a;
            pb    <= b;
            dist2 <= '0;
            cnt   <= '0;
            phase <= PH_SUM;
          end
        end
        PH_SUM: begin
          dist2 <= sum;
          if (cnt == 5'd2) begin
            xs    <= sum;
            rem   <= '0;
            root  <= '0;
            cnt   <= '0;
            phase <= PH_ROOT;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        PH_ROOT: begin
          xs <= {xs[gapf_pkg::D2_W-3:0], 2'b00};
          if (rsh >= trial) begin
            rem  <= (gapf_pkg::RT_W+1)'(rsh - trial);
            root <= {root[gapf_pkg::RT_W-2:0], 1'b1};
          end else begin
            rem  <= rsh[gapf_pkg::RT_W:0];
            root <= {root[gapf_pkg::RT_W-2:0], 1'b0};
          end
          cnt  <= cnt + 5'd1;
          done <= (cnt == 5'(gapf_pkg::RT_W - 1));
          if (cnt == 5'(gapf_pkg::RT_W - 1)) begin
            phase <= PH_IDLE;
          end
        end
        default: begin
          phase <= PH_IDLE;
          done  <= 1'b0;
        end
      endcase
    end
  end

endmodule

### src/graph_astar_path_finder_unit.sv
// Top level of the graph A* path finder: node table, adjacency rows, A* search.
// Depends on gapf_pkg, gapf_ram and gapf_dist.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  req     | in        | req_valid/req_ready  | gapf_pkg::req_t, one action
//  rsp     | out       | rsp_valid/rsp_ready  | gapf_pkg::rsp_t, 1..MAX_NODES+1
//
// Every distance goes through the one shared distance unit, after the reads
// of the point memory for the node pair. Auto connect measures every ordered
// pair of distinct stored nodes; a path query first snaps start and goal with
// one distance per stored node each, then per expanded node scans the open
// list and measures each edge to a node not yet closed, plus a second distance
// to the goal when that edge lowers a cost.
// Reset is synchronous and needs no clearing pass: adjacency rows carry valid
// bits and the per-query search flags are flip-flops. A stalled rsp channel
// only holds the sequencer at its next result; a new req transaction is taken
// whenever the sequencer is idle, even while the last result waits.
module graph_astar_path_finder_unit #(
  parameter int MAX_NODES = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  gapf_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output gapf_pkg::rsp_t   rsp
);

  localparam int IW  = $clog2(MAX_NODES);
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int PW  = IW + 1;
  localparam int NSW = 2 * gapf_pkg::COST_W + PW;
  localparam logic [PW-1:0] PRED_NONE = '1;

  // Sequencer states.
  localparam logic [5:0] S_IDLE     = 6'd0;
  localparam logic [5:0] S_DECODE   = 6'd1;
  localparam logic [5:0] S_EMIT     = 6'd2;
  localparam logic [5:0] S_CN_RA    = 6'd3;
  localparam logic [5:0] S_CN_WA    = 6'd4;
  localparam logic [5:0] S_CN_RB    = 6'd5;
  localparam logic [5:0] S_CN_WB    = 6'd6;
  localparam logic [5:0] S_AU_ROW   = 6'd7;
  localparam logic [5:0] S_AU_COL   = 6'd8;
  localparam logic [5:0] S_AU_CHK   = 6'd9;
  localparam logic [5:0] S_AU_WR    = 6'd10;
  localparam logic [5:0] S_P_RA     = 6'd11;
  localparam logic [5:0] S_P_RB     = 6'd12;
  localparam logic [5:0] S_P_GO     = 6'd13;
  localparam logic [5:0] S_P_WAIT   = 6'd14;
  localparam logic [5:0] S_SN_NEXT  = 6'd15;
  localparam logic [5:0] S_SN_CHK   = 6'd16;
  localparam logic [5:0] S_AS_INIT  = 6'd17;
  localparam logic [5:0] S_AS_INIT2 = 6'd18;
  localparam logic [5:0] S_SE_RD    = 6'd19;
  localparam logic [5:0] S_SE_CK    = 6'd20;
  localparam logic [5:0] S_SE_END   = 6'd21;
  localparam logic [5:0] S_EX_ADJ   = 6'd22;
  localparam logic [5:0] S_EX_ROW   = 6'd23;
  localparam logic [5:0] S_EX_COL   = 6'd24;
  localparam logic [5:0] S_EX_RDC   = 6'd25;
  localparam logic [5:0] S_EX_CMP   = 6'd26;
  localparam logic [5:0] S_EX_H     = 6'd27;
  localparam logic [5:0] S_TR_RD    = 6'd28;
  localparam logic [5:0] S_TR_CK    = 6'd29;
  localparam logic [5:0] S_OU_START = 6'd30;
  localparam logic [5:0] S_OU_NEXT  = 6'd31;
  localparam logic [5:0] S_OU_RPOS  = 6'd32;
  localparam logic [5:0] S_OU_EM    = 6'd33;

  // Control state.
  logic [5:0]           st;
  logic [5:0]           p_ret;
  logic [5:0]           em_ret;
  logic                 out_valid;
  logic [CW-1:0]        count;
  logic [MAX_NODES-1:0] adj_vld;
  logic [MAX_NODES-1:0] open_f;
  logic [MAX_NODES-1:0] closed_f;

  // Working registers.
  gapf_pkg::req_t              inq;
  gapf_pkg::rsp_t              res;
  gapf_pkg::rsp_t              out_q;
  gapf_pkg::point_t            pa;
  logic [IW-1:0]               pr_a;
  logic [IW-1:0]               pr_b;
  logic                        pr_bram;
  logic                        snap_sel;
  logic [CW-1:0]               i_idx;
  logic [CW-1:0]               j_idx;
  logic [CW-1:0]               len;
  logic [MAX_NODES-1:0]        rowacc;
  logic [MAX_NODES-1:0]        cur_row;
  logic [IW-1:0]               best;
  logic [gapf_pkg::D2_W-1:0]   bd;
  logic [IW-1:0]               s_idx;
  logic [IW-1:0]               g_idx;
  logic [IW-1:0]               cur;
  logic                        found;
  logic [gapf_pkg::COST_W-1:0] best_est;
  logic [gapf_pkg::COST_W-1:0] cur_cost;
  logic [gapf_pkg::COST_W-1:0] ed_t;
  logic [IW-1:0]               tn;
  logic [IW-1:0]               nd;

  // Memory ports.
  logic                  pos_we;
  logic [IW-1:0]         pos_waddr;
  logic [IW-1:0]         pos_raddr;
  gapf_pkg::point_t      pos_wdata;
  gapf_pkg::point_t      pos_q;
  logic                  adj_we;
  logic [IW-1:0]         adj_waddr;
  logic [IW-1:0]         adj_raddr;
  logic [MAX_NODES-1:0]  adj_wdata;
  logic [MAX_NODES-1:0]  adj_q;
  logic                  ns_we;
  logic [IW-1:0]         ns_waddr;
  logic [IW-1:0]         ns_raddr;
  logic [NSW-1:0]        ns_wdata;
  logic [NSW-1:0]        ns_q;
  logic                  pb_we;
  logic [IW-1:0]         pb_raddr;
  logic [IW-1:0]         pb_q;

  // Distance unit.
  logic                      d_start;
  logic                      d_done;
  gapf_pkg::point_t          d_b;
  logic [gapf_pkg::D2_W-1:0] d_dist2;
  logic [gapf_pkg::RT_W-1:0] d_root;

  // Decoded helpers.
  logic [IW-1:0]               a_idx;
  logic [IW-1:0]               b_idx;
  logic [IW-1:0]               i_ix;
  logic [IW-1:0]               j_ix;
  logic [IW-1:0]               jm1_ix;
  gapf_pkg::point_t            start_pt;
  gapf_pkg::point_t            goal_pt;
  gapf_pkg::point_t            pr_bext;
  logic [MAX_NODES-1:0]        row_cur;
  logic [gapf_pkg::COST_W-1:0] ns_cost;
  logic [gapf_pkg::COST_W-1:0] ns_est;
  logic [PW-1:0]               ns_pred;
  logic [gapf_pkg::COST_W-1:0] cost_j;
  logic                        bad_pair;

  function automatic gapf_pkg::rsp_t mk_res(input logic [2:0] status,
                                            input logic [IW-1:0] idx,
                                            input logic [1:0] kind,
                                            input gapf_pkg::point_t p,
                                            input logic last);
    gapf_pkg::rsp_t r;
    r.status     = status;
    r.node_index = gapf_pkg::IDX_W'(idx);
    r.point_kind = kind;
    r.out_x      = p.x;
    r.out_y      = p.y;
    r.out_z      = p.z;
    r.last       = last;
    return r;
  endfunction

  assign req_ready = (st == S_IDLE);
  assign rsp_valid = out_valid;
  assign rsp       = out_q;

  assign a_idx    = IW'(inq.node_a);
  assign b_idx    = IW'(inq.node_b);
  assign i_ix     = i_idx[IW-1:0];
  assign j_ix     = j_idx[IW-1:0];
  assign jm1_ix   = IW'(j_idx - 1'b1);
  assign start_pt = '{x: inq.pos_x, y: inq.pos_y, z: inq.pos_z};
  assign goal_pt  = '{x: inq.goal_x, y: inq.goal_y, z: inq.goal_z};
  assign pr_bext  = snap_sel ? goal_pt : start_pt;
  assign ns_cost  = ns_q[NSW-1 -: gapf_pkg::COST_W];
  assign ns_est   = ns_q[NSW-gapf_pkg::COST_W-1 -: gapf_pkg::COST_W];
  assign ns_pred  = ns_q[PW-1:0];
  // A node never touched in this query still has infinite cost.
  assign cost_j   = open_f[j_ix] ? ns_cost : gapf_pkg::COST_INF;
  // An adjacency row that was never written since reset or auto connect is empty.
  assign row_cur  = adj_vld[adj_raddr] ? adj_q : '0;
  assign bad_pair = (32'(inq.node_a) >= 32'(count)) || (32'(inq.node_b) >= 32'(count));

  assign d_start = (st == S_P_GO);
  assign d_b     = pr_bram ? pos_q : pr_bext;

  // Memory address and write selection per sequencer state.
  always_comb begin
    pos_we    = 1'b0;
    pos_waddr = count[IW-1:0];
    pos_wdata = start_pt;
    pos_raddr = pr_a;
    adj_we    = 1'b0;
    adj_waddr = a_idx;
    adj_wdata = row_cur | ({{(MAX_NODES-1){1'b0}}, 1'b1} << b_idx);
    adj_raddr = cur;
    ns_we     = 1'b0;
    ns_waddr  = j_ix;
    ns_wdata  = {ed_t, gapf_pkg::sat_add(ed_t, d_root), {1'b0, cur}};
    ns_raddr  = i_ix;
    pb_we     = 1'b0;
    pb_raddr  = jm1_ix;
    unique case (st)
      S_DECODE: pos_we = (inq.action == gapf_pkg::ACT_ADD) &&
                         (count != CW'(MAX_NODES));
      S_CN_RA:  adj_raddr = a_idx;
      S_CN_WA:  begin
        adj_raddr = a_idx;
        adj_we    = 1'b1;
      end
      S_CN_RB:  adj_raddr = b_idx;
      S_CN_WB:  begin
        adj_raddr = b_idx;
        adj_we    = 1'b1;
        adj_waddr = b_idx;
        adj_wdata = row_cur | ({{(MAX_NODES-1){1'b0}}, 1'b1} << a_idx);
      end
      S_AU_WR:  begin
        adj_we    = 1'b1;
        adj_waddr = i_ix;
        adj_wdata = rowacc;
      end
      S_P_RB:   pos_raddr = pr_b;
      S_P_GO:   pos_raddr = pr_b;
      S_AS_INIT2: begin
        ns_we    = 1'b1;
        ns_waddr = s_idx;
        ns_wdata = {{gapf_pkg::COST_W{1'b0}},
                    gapf_pkg::sat_add('0, d_root), PRED_NONE};
      end
      S_EX_RDC: ns_raddr = j_ix;
      S_EX_H:   ns_we = 1'b1;
      S_TR_RD:  begin
        ns_raddr = tn;
        pb_we    = (len != CW'(MAX_NODES));
      end
      S_OU_RPOS: pos_raddr = pb_q;
      S_OU_EM:   pos_raddr = nd;
      default: ;
    endcase
  end

  gapf_ram #(.WIDTH($bits(gapf_pkg::point_t)), .DEPTH(MAX_NODES)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(pos_raddr), .rdata(pos_q)
  );

  gapf_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj_ram (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .raddr(adj_raddr), .rdata(adj_q)
  );

  // Per-node search state: cost so far, total estimate, predecessor.
  gapf_ram #(.WIDTH(NSW), .DEPTH(MAX_NODES)) u_ns_ram (
    .clk(clk), .we(ns_we), .waddr(ns_waddr), .wdata(ns_wdata),
    .raddr(ns_raddr), .rdata(ns_q)
  );

  // Path trace buffer, goal first.
  gapf_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_path_ram (
    .clk(clk), .we(pb_we), .waddr(len[IW-1:0]), .wdata(tn),
    .raddr(pb_raddr), .rdata(pb_q)
  );

  gapf_dist u_dist (
    .clk(clk), .rst(rst), .start(d_start), .a(pa), .b(d_b),
    .done(d_done), .dist2(d_dist2), .root(d_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
      adj_vld   <= '0;
      open_f    <= '0;
      closed_f  <= '0;
    end else begin
      // The emit state reloads the output register itself.
      if (out_valid && rsp_ready && (st != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (req_valid) begin
            inq <= req;
            st  <= S_DECODE;
          end
        end

        S_DECODE: begin
          em_ret <= S_IDLE;
          unique case (inq.action)
            gapf_pkg::ACT_ADD: begin
              st <= S_EMIT;
              if (count == CW'(MAX_NODES)) begin
                res <= mk_res(gapf_pkg::ST_FULL, '0, gapf_pkg::KIND_START, '0, 1'b1);
              end else begin
                res   <= mk_res(gapf_pkg::ST_OK, count[IW-1:0],
                                gapf_pkg::KIND_START, '0, 1'b1);
                count <= count + 1'b1;
              end
            end
            gapf_pkg::ACT_CONNECT: begin
              if (bad_pair) begin
                res <= mk_res(gapf_pkg::ST_BAD_IDX, '0, gapf_pkg::KIND_START, '0, 1'b1);
                st  <= S_EMIT;
              end else begin
                st <= S_CN_RA;
              end
            end
            gapf_pkg::ACT_AUTO: begin
              adj_vld <= '0;
              i_idx   <= '0;
              st      <= S_AU_ROW;
            end
            default: begin
              if (count == '0) begin
                res <= mk_res(gapf_pkg::ST_EMPTY, '0, gapf_pkg::KIND_START, '0, 1'b1);
                st  <= S_EMIT;
              end else begin
                snap_sel <= 1'b0;
                i_idx    <= '0;
                st       <= S_SN_NEXT;
              end
            end
          endcase
        end

        S_EMIT: begin
          if (!out_valid || rsp_ready) begin
            out_q     <= res;
            out_valid <= 1'b1;
            st        <= em_ret;
          end
        end

        // Connect: read-modify-write of both rows; a self link sees its own update.
        S_CN_RA: st <= S_CN_WA;
        S_CN_WA: begin
          adj_vld[a_idx] <= 1'b1;
          st             <= S_CN_RB;
        end
        S_CN_RB: st <= S_CN_WB;
        S_CN_WB: begin
          adj_vld[b_idx] <= 1'b1;
          res            <= mk_res(gapf_pkg::ST_OK, '0, gapf_pkg::KIND_START, '0, 1'b1);
          st             <= S_EMIT;
        end

        // Auto connect builds each row in full from the distance to every other node.
        S_AU_ROW: begin
          if (i_idx == count) begin
            res <= mk_res(gapf_pkg::ST_OK, '0, gapf_pkg::KIND_START, '0, 1'b1);
            st  <= S_EMIT;
          end else begin
            rowacc <= '0;
            j_idx  <= '0;
            st     <= S_AU_COL;
          end
        end
        S_AU_COL: begin
          if (j_idx == count) begin
            st <= S_AU_WR;
          end else if (j_idx == i_idx) begin
            j_idx <= j_idx + 1'b1;
          end else begin
            pr_a    <= i_ix;
            pr_b    <= j_ix;
            pr_bram <= 1'b1;
            p_ret   <= S_AU_CHK;
            st      <= S_P_RA;
          end
        end
        S_AU_CHK: begin
          if (gapf_pkg::LIM_W'(d_root) <= inq.max_distance) begin
            rowacc[j_ix] <= 1'b1;
          end
          j_idx <= j_idx + 1'b1;
          st    <= S_AU_COL;
        end
        S_AU_WR: begin
          adj_vld[i_ix] <= 1'b1;
          i_idx         <= i_idx + 1'b1;
          st            <= S_AU_ROW;
        end

        // Pair load: point A from memory, point B from memory or the request.
        S_P_RA: st <= S_P_RB;
        S_P_RB: begin
          pa <= pos_q;
          st <= S_P_GO;
        end
        S_P_GO: st <= S_P_WAIT;
        S_P_WAIT: begin
          if (d_done) begin
            st <= p_ret;
          end
        end

        // Snap start, then goal, to the nearest node; ties keep the lower index.
        S_SN_NEXT: begin
          if (i_idx == count) begin
            i_idx <= '0;
            if (!snap_sel) begin
              s_idx    <= best;
              snap_sel <= 1'b1;
            end else begin
              g_idx <= best;
              st    <= S_AS_INIT;
            end
          end else begin
            pr_a    <= i_ix;
            pr_bram <= 1'b0;
            p_ret   <= S_SN_CHK;
            st      <= S_P_RA;
          end
        end
        S_SN_CHK: begin
          if ((i_idx == '0) || (d_dist2 < bd)) begin
            bd   <= d_dist2;
            best <= i_ix;
          end
          i_idx <= i_idx + 1'b1;
          st    <= S_SN_NEXT;
        end

        S_AS_INIT: begin
          open_f   <= '0;
          closed_f <= '0;
          pr_a     <= s_idx;
          pr_b     <= g_idx;
          pr_bram  <= 1'b1;
          p_ret    <= S_AS_INIT2;
          st       <= S_P_RA;
        end
        S_AS_INIT2: begin
          open_f[s_idx] <= 1'b1;
          i_idx         <= '0;
          found         <= 1'b0;
          st            <= S_SE_RD;
        end

        // Open list scan for the lowest estimate; strict compare keeps the lower index.
        S_SE_RD: begin
          st <= (i_idx == count) ? S_SE_END : S_SE_CK;
        end
        S_SE_CK: begin
          if (open_f[i_ix] && !closed_f[i_ix] && (!found || (ns_est < best_est))) begin
            found    <= 1'b1;
            best_est <= ns_est;
            cur      <= i_ix;
            cur_cost <= ns_cost;
          end
          i_idx <= i_idx + 1'b1;
          st    <= S_SE_RD;
        end
        S_SE_END: begin
          if (!found) begin
            res <= mk_res(gapf_pkg::ST_NO_PATH, '0, gapf_pkg::KIND_START, '0, 1'b1);
            st  <= S_EMIT;
          end else begin
            closed_f[cur] <= 1'b1;
            if (cur == g_idx) begin
              tn  <= g_idx;
              len <= '0;
              st  <= S_TR_RD;
            end else begin
              st <= S_EX_ADJ;
            end
          end
        end

        // Expand the chosen node over its adjacency row.
        S_EX_ADJ: st <= S_EX_ROW;
        S_EX_ROW: begin
          cur_row <= row_cur;
          j_idx   <= '0;
          st      <= S_EX_COL;
        end
        S_EX_COL: begin
          if (j_idx == count) begin
            i_idx <= '0;
            found <= 1'b0;
            st    <= S_SE_RD;
          end else if (cur_row[j_ix] && !closed_f[j_ix]) begin
            pr_a    <= cur;
            pr_b    <= j_ix;
            pr_bram <= 1'b1;
            p_ret   <= S_EX_RDC;
            st      <= S_P_RA;
          end else begin
            j_idx <= j_idx + 1'b1;
          end
        end
        S_EX_RDC: begin
          ed_t <= gapf_pkg::sat_add(cur_cost, d_root);
          st   <= S_EX_CMP;
        end
        S_EX_CMP: begin
          if (ed_t < cost_j) begin
            pr_a    <= j_ix;
            pr_b    <= g_idx;
            pr_bram <= 1'b1;
            p_ret   <= S_EX_H;
            st      <= S_P_RA;
          end else begin
            j_idx <= j_idx + 1'b1;
            st    <= S_EX_COL;
          end
        end
        S_EX_H: begin
          open_f[j_ix] <= 1'b1;
          j_idx        <= j_idx + 1'b1;
          st           <= S_EX_COL;
        end

        // Walk predecessors back from the goal into the path buffer.
        S_TR_RD: begin
          if (len == CW'(MAX_NODES)) begin
            st <= S_OU_START;
          end else begin
            len <= len + 1'b1;
            st  <= S_TR_CK;
          end
        end
        S_TR_CK: begin
          if (ns_pred == PRED_NONE) begin
            st <= S_OU_START;
          end else begin
            tn <= ns_pred[IW-1:0];
            st <= S_TR_RD;
          end
        end

        // Emit exact start, path nodes after the first, then exact goal.
        S_OU_START: begin
          res    <= mk_res(gapf_pkg::ST_OK, s_idx, gapf_pkg::KIND_START, start_pt, 1'b0);
          j_idx  <= len - 1'b1;
          em_ret <= S_OU_NEXT;
          st     <= S_EMIT;
        end
        S_OU_NEXT: begin
          if (j_idx == '0) begin
            res    <= mk_res(gapf_pkg::ST_OK, g_idx, gapf_pkg::KIND_GOAL, goal_pt, 1'b1);
            em_ret <= S_IDLE;
            st     <= S_EMIT;
          end else begin
            st <= S_OU_RPOS;
          end
        end
        S_OU_RPOS: begin
          nd <= pb_q;
          st <= S_OU_EM;
        end
        S_OU_EM: begin
          res    <= mk_res(gapf_pkg::ST_OK, nd, gapf_pkg::KIND_MESH, pos_q, 1'b0);
          j_idx  <= j_idx - 1'b1;
          em_ret <= S_OU_NEXT;
          st     <= S_EMIT;
        end

        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

### src/gapf_check.sv
// Port-level checker for the graph A* path finder, bound to the top level.
// Depends on gapf_pkg and graph_astar_path_finder_unit.
module gapf_check (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input gapf_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input gapf_pkg::rsp_t rsp
);

  // A stalled result transaction holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // The block is busy right after taking a request.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while still working");

  // Any error status ends the request's results.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != gapf_pkg::ST_OK) |-> rsp.last)
    else $error("error result not marked last");

  // The exact goal point is always the final result.
  a_goal_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.point_kind == gapf_pkg::KIND_GOAL) |-> rsp.last)
    else $error("goal point not marked last");

endmodule

bind graph_astar_path_finder_unit gapf_check u_gapf_check (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
  .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);

### tb/tb_graph_astar_path_finder_unit.sv
// Self-checking testbench for graph_astar_path_finder_unit: add, connect,
// auto connect and path queries checked against an in-bench A* predictor.
// Depends on gapf_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_graph_astar_path_finder_unit;

  localparam int NMAX = 32;
  localparam logic [5:0] PRED_NIL = 6'h3F;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  gapf_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  gapf_pkg::rsp_t rsp;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  graph_astar_path_finder_unit dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  // Predictor state: the node table and the adjacency matrix.
  int unsigned mesh_count;
  gapf_pkg::point_t mesh_pt[NMAX];
  bit mesh_adj[NMAX][NMAX];

  gapf_pkg::req_t pending_reqs[$];
  gapf_pkg::rsp_t expected_rsps[$];
  int errors = 0;
  bit hold_rx = 1'b0;

  // Appends one transaction at the tail of a queue.
  function automatic void expect_rsp(gapf_pkg::rsp_t r);
    expected_rsps.insert(expected_rsps.size(), r);
  endfunction

  function automatic void queue_req(gapf_pkg::req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  function automatic longint unsigned sq_dist(gapf_pkg::point_t a, gapf_pkg::point_t b);
    longint dx, dy, dz;
    dx = longint'(a.x) - longint'(b.x);
    dy = longint'(a.y) - longint'(b.y);
    dz = longint'(a.z) - longint'(b.z);
    return longint'(dx * dx + dy * dy + dz * dz);
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [gapf_pkg::COST_W-1:0] cost_add(longint unsigned a,
                                                           longint unsigned b);
    return (a + b > gapf_pkg::COST_MAX) ? gapf_pkg::COST_MAX : gapf_pkg::COST_W'(a + b);
  endfunction

  function automatic int unsigned snap_node(gapf_pkg::point_t p);
    int unsigned best;
    longint unsigned bd, d;
    best = 0;
    bd = sq_dist(mesh_pt[0], p);
    for (int i = 1; i < mesh_count; i++) begin
      d = sq_dist(mesh_pt[i], p);
      if (d < bd) begin
        bd = d;
        best = i;
      end
    end
    return best;
  endfunction

  function automatic gapf_pkg::rsp_t mk_rsp(logic [2:0] st, int unsigned idx,
                                            logic [1:0] kind, gapf_pkg::point_t p,
                                            bit fin);
    gapf_pkg::rsp_t r;
    r = '0;
    r.status = st;
    r.node_index = gapf_pkg::IDX_W'(idx);
    r.point_kind = kind;
    r.out_x = p.x;
    r.out_y = p.y;
    r.out_z = p.z;
    r.last = fin;
    return r;
  endfunction

  // Applies one transaction to the predictor and queues the results it causes.
  function automatic void predict_path_results(gapf_pkg::req_t q);
    gapf_pkg::point_t sp, gp, zp;
    int unsigned s, g, cur, n, len, a, b;
    bit closed[NMAX], open[NMAX];
    logic [gapf_pkg::COST_W-1:0] gcost[NMAX], fcost[NMAX], t;
    logic [5:0] pred[NMAX];
    int unsigned trail[NMAX];
    bit found;
    sp = '{q.pos_x, q.pos_y, q.pos_z};
    gp = '{q.goal_x, q.goal_y, q.goal_z};
    zp = '0;
    case (q.action)
      gapf_pkg::ACT_ADD: begin
        if (mesh_count >= NMAX) begin
          expect_rsp(mk_rsp(gapf_pkg::ST_FULL, 0, gapf_pkg::KIND_START, zp, 1));
        end else begin
          mesh_pt[mesh_count] = sp;
          expect_rsp(mk_rsp(gapf_pkg::ST_OK, mesh_count, gapf_pkg::KIND_START, zp, 1));
          mesh_count++;
        end
      end
      gapf_pkg::ACT_CONNECT: begin
        a = q.node_a;
        b = q.node_b;
        if (a >= mesh_count || b >= mesh_count) begin
          expect_rsp(mk_rsp(gapf_pkg::ST_BAD_IDX, 0, gapf_pkg::KIND_START, zp, 1));
        end else begin
          mesh_adj[a][b] = 1;
          mesh_adj[b][a] = 1;
          expect_rsp(mk_rsp(gapf_pkg::ST_OK, 0, gapf_pkg::KIND_START, zp, 1));
        end
      end
      gapf_pkg::ACT_AUTO: begin
        for (int i = 0; i < NMAX; i++)
          for (int j = 0; j < NMAX; j++) mesh_adj[i][j] = 0;
        for (int i = 0; i < mesh_count; i++)
          for (int j = i + 1; j < mesh_count; j++)
            if (floor_root(sq_dist(mesh_pt[i], mesh_pt[j])) <= q.max_distance) begin
              mesh_adj[i][j] = 1;
              mesh_adj[j][i] = 1;
            end
        expect_rsp(mk_rsp(gapf_pkg::ST_OK, 0, gapf_pkg::KIND_START, zp, 1));
      end
      default: begin
        if (mesh_count == 0) begin
          expect_rsp(mk_rsp(gapf_pkg::ST_EMPTY, 0, gapf_pkg::KIND_START, zp, 1));
          return;
        end
        s = snap_node(sp);
        g = snap_node(gp);
        for (int i = 0; i < NMAX; i++) begin
          closed[i] = 0;
          open[i] = 0;
          gcost[i] = gapf_pkg::COST_INF;
          fcost[i] = '0;
          pred[i] = PRED_NIL;
        end
        gcost[s] = '0;
        fcost[s] = cost_add(0, floor_root(sq_dist(mesh_pt[s], mesh_pt[g])));
        open[s] = 1;
        found = 0;
        forever begin
          cur = NMAX;
          for (int i = 0; i < mesh_count; i++)
            if (open[i] && !closed[i] && (cur == NMAX || fcost[i] < fcost[cur])) cur = i;
          if (cur == NMAX) break;
          closed[cur] = 1;
          if (cur == g) begin
            found = 1;
            break;
          end
          for (int i = 0; i < mesh_count; i++) begin
            if (!mesh_adj[cur][i] || closed[i]) continue;
            t = cost_add(gcost[cur], floor_root(sq_dist(mesh_pt[cur], mesh_pt[i])));
            if (t < gcost[i]) begin
              gcost[i] = t;
              pred[i] = 6'(cur);
              fcost[i] = cost_add(t, floor_root(sq_dist(mesh_pt[i], mesh_pt[g])));
              open[i] = 1;
            end
          end
        end
        if (!found) begin
          expect_rsp(mk_rsp(gapf_pkg::ST_NO_PATH, 0, gapf_pkg::KIND_START, zp, 1));
          return;
        end
        len = 0;
        n = g;
        while (n < NMAX && len < NMAX) begin
          trail[len++] = n;
          n = pred[n];
        end
        expect_rsp(mk_rsp(gapf_pkg::ST_OK, s, gapf_pkg::KIND_START, sp, 0));
        for (int i = len - 1; i > 0; i--)
          expect_rsp(mk_rsp(gapf_pkg::ST_OK, trail[i-1], gapf_pkg::KIND_MESH,
                            mesh_pt[trail[i-1]], 0));
        expect_rsp(mk_rsp(gapf_pkg::ST_OK, g, gapf_pkg::KIND_GOAL, gp, 1));
      end
    endcase
  endfunction

  // Random gap: mostly zero or short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic gapf_pkg::req_t rand_req(logic [1:0] act);
    gapf_pkg::req_t q;
    q = gapf_pkg::req_t'({$urandom, $urandom, $urandom, $urandom});
    q.action = act;
    return q;
  endfunction

  // Coordinates in a small box so that auto connect forms real meshes.
  function automatic logic signed [gapf_pkg::CRD_W-1:0] near_crd();
    return gapf_pkg::CRD_W'($signed($urandom_range(0, 1600)) - 800);
  endfunction

  function automatic gapf_pkg::req_t build_req(logic [1:0] act,
                                               logic signed [gapf_pkg::CRD_W-1:0] x,
                                               logic signed [gapf_pkg::CRD_W-1:0] y,
                                               logic signed [gapf_pkg::CRD_W-1:0] z);
    gapf_pkg::req_t q;
    q = rand_req(act);
    q.pos_x = x;
    q.pos_y = y;
    q.pos_z = z;
    return q;
  endfunction

  // Driver: offers queued transactions with random gaps between them.
  int unsigned tx_gap = 0;
  always @(posedge clk) begin
    int unsigned g;
    if (!rst) begin
      if (req_valid && req_ready) begin
        predict_path_results(req);
        g = gap_len();
        if (g == 0 && pending_reqs.size() > 0) begin
          req <= pending_reqs.pop_front();
          tx_gap <= 0;
        end else begin
          req_valid <= 1'b0;
          tx_gap <= g;
        end
      end else if (!req_valid) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
        end else if (pending_reqs.size() > 0) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: compares each result transaction with the oldest expectation.
  int unsigned rx_gap = 0;
  always @(posedge clk) begin
    gapf_pkg::rsp_t e;
    int unsigned g;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result %p", $time, rsp);
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          if (rsp !== e) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, e, rsp);
            errors++;
          end
        end
      end
      if (hold_rx) begin
        rsp_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        rsp_ready <= 1'b0;
      end else if (rsp_ready && rsp_valid) begin
        g = gap_len();
        rx_gap <= g;
        rsp_ready <= (g == 0);
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off counted in its own process so the input stalls.
  initial begin
    wait (!rst);
    repeat (3000) @(posedge clk);
    hold_rx = 1'b1;
    repeat (6000) @(posedge clk);
    hold_rx = 1'b0;
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    gapf_pkg::req_t q;
    int unsigned k;
    for (int i = 0; i < NMAX; i++)
      for (int j = 0; j < NMAX; j++) mesh_adj[i][j] = 0;
    mesh_count = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty mesh, bad indices, extremes, self link, no route,
    // same start and goal node, ties in snapping.
    queue_req(rand_req(gapf_pkg::ACT_FIND));
    q = rand_req(gapf_pkg::ACT_CONNECT);
    q.node_a = 0;
    q.node_b = 0;
    queue_req(q);
    queue_req(build_req(gapf_pkg::ACT_ADD, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
    queue_req(build_req(gapf_pkg::ACT_ADD, -16'sh8000, -16'sh8000, -16'sh8000));
    queue_req(build_req(gapf_pkg::ACT_ADD, 0, 0, 0));
    queue_req(build_req(gapf_pkg::ACT_ADD, 0, 0, 0));
    queue_req(build_req(gapf_pkg::ACT_ADD, 100, 0, 0));
    q = rand_req(gapf_pkg::ACT_CONNECT);
    q.node_a = 5'd31;
    q.node_b = 5'd0;
    queue_req(q);
    q.node_a = 5'd1;
    q.node_b = 5'd1;
    queue_req(q);
    q = build_req(gapf_pkg::ACT_FIND, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    q.goal_x = 50; q.goal_y = 0; q.goal_z = 0;
    queue_req(q);
    q = build_req(gapf_pkg::ACT_FIND, 1, 0, 0);
    q.goal_x = 2; q.goal_y = 0; q.goal_z = 0;
    queue_req(q);
    q = rand_req(gapf_pkg::ACT_AUTO);
    q.max_distance = '1;
    queue_req(q);
    q = build_req(gapf_pkg::ACT_FIND, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    q.goal_x = -16'sh8000; q.goal_y = -16'sh8000; q.goal_z = -16'sh8000;
    queue_req(q);
    q = rand_req(gapf_pkg::ACT_AUTO);
    q.max_distance = '0;
    queue_req(q);
    q = build_req(gapf_pkg::ACT_FIND, 0, 0, 0);
    q.goal_x = 100; q.goal_y = 0; q.goal_z = 0;
    queue_req(q);
    q = rand_req(gapf_pkg::ACT_AUTO);
    q.max_distance = 18'd100;
    queue_req(q);
    queue_req(q);
    q = build_req(gapf_pkg::ACT_FIND, 0, 0, 0);
    q.goal_x = 100; q.goal_y = 0; q.goal_z = 0;
    queue_req(q);
    wait_drained();

    // Random part: fill the table with nearby points, link them and query,
    // with scattered noise items of any value.
    k = 0;
    while (k < 122) begin
      case ($urandom_range(0, 9))
        0, 1, 2: q = build_req(gapf_pkg::ACT_ADD, near_crd(), near_crd(), near_crd());
        3: begin
          q = rand_req(gapf_pkg::ACT_CONNECT);
          if ($urandom_range(0, 3) != 0 && mesh_count > 0) begin
            q.node_a = gapf_pkg::IDX_W'($urandom_range(0, NMAX - 1) % (mesh_count + 1));
            q.node_b = gapf_pkg::IDX_W'($urandom_range(0, NMAX - 1) % (mesh_count + 1));
          end
        end
        4: begin
          q = rand_req(gapf_pkg::ACT_AUTO);
          if ($urandom_range(0, 3) != 0)
            q.max_distance = gapf_pkg::LIM_W'($urandom_range(200, 1500));
        end
        5: q = rand_req(2'($urandom_range(0, 3)));
        default: begin
          q = build_req(gapf_pkg::ACT_FIND, near_crd(), near_crd(), near_crd());
          q.goal_x = near_crd(); q.goal_y = near_crd(); q.goal_z = near_crd();
        end
      endcase
      queue_req(q);
      k++;
    end
    wait_drained();
    repeat (2000) @(posedge clk);
    if (errors == 0 && expected_rsps.size() == 0)
      $display("tb_graph_astar_path_finder_unit OK");
    else
      $display("tb_graph_astar_path_finder_unit NOT OK");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("tb_graph_astar_path_finder_unit NOT OK");
    $finish;
  end

endmodule
